// File: rtl/fbfa_pkg.sv
// Package for the free block fit allocator: field widths, command, status,
// policy and register codes, controller states and shared structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbfa_pkg;

    localparam int unsigned SIZE_W   = 16;
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned POL_W    = 2;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    // Commands
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Fit policies (the unused code behaves as first fit)
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_REMNANT = 1'd1;

    localparam logic [SIZE_W-1:0] MIN_REMNANT_RESET = 16'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_state;

    // Command word held for the whole scan and write-back
    typedef struct packed {
        logic              cmd;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic [POL_W-1:0]  policy;
        logic [SIZE_W-1:0] min_rem;
    } t_req;

    // Best candidate so far, handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
    } t_pick;

endpackage

`default_nettype wire

// File: rtl/fbfa_if.sv
// Handshake interfaces for the free block fit allocator: command input,
// result output and register write channel. Depends on fbfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface fbfa_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [fbfa_pkg::SIZE_W-1:0] block_size;
    logic [fbfa_pkg::ADDR_W-1:0] block_addr;

    modport source (output valid, cmd, block_size, block_addr, input ready);
    modport sink   (input valid, cmd, block_size, block_addr, output ready);
endinterface

interface fbfa_out_if;
    logic                          valid;
    logic                          ready;
    logic [fbfa_pkg::STATUS_W-1:0] status;
    logic [fbfa_pkg::ADDR_W-1:0]   alloc_addr;

    modport source (output valid, status, alloc_addr, input ready);
    modport sink   (input valid, status, alloc_addr, output ready);
endinterface

interface fbfa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [fbfa_pkg::CFG_IDX_W-1:0]  index;
    logic [fbfa_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/fbfa_cell.sv
// One table slot of the allocator: holds size, start address and valid,
// weighs itself against the candidate from its left neighbour and applies
// the write-back when selected. Depends on fbfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbfa_cell #(
    parameter int unsigned SLOT_W = 4,
    parameter int unsigned SLOT   = 0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire fbfa_pkg::t_req              i_req,
    input  wire fbfa_pkg::t_pick             i_pick,
    input  wire logic [SLOT_W-1:0]           i_slot,
    input  wire logic                        i_wr_en,
    input  wire logic [SLOT_W-1:0]           i_wr_slot,
    output fbfa_pkg::t_pick                  o_pick,
    output logic [SLOT_W-1:0]                o_slot
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(SLOT);

    logic [fbfa_pkg::SIZE_W-1:0] r_size;
    logic [fbfa_pkg::ADDR_W-1:0] r_addr;
    logic                        r_valid;

    fbfa_pkg::t_pick             r_pick;
    logic [SLOT_W-1:0]           r_slot;

    logic                        fits;
    logic                        better;
    logic                        take;
    logic [fbfa_pkg::SIZE_W-1:0] rem_size;

    // Compare own entry with the incoming candidate; on equal size the lower address wins
    always_comb begin
        fits = r_valid && (r_size >= i_req.size);
        unique case (i_req.policy)
            fbfa_pkg::POL_BEST: begin
                better = (r_size < i_pick.size) ||
                         ((r_size == i_pick.size) && (r_addr < i_pick.addr));
            end
            fbfa_pkg::POL_WORST: begin
                better = (r_size > i_pick.size) ||
                         ((r_size == i_pick.size) && (r_addr < i_pick.addr));
            end
            default: begin
                better = r_addr < i_pick.addr;
            end
        endcase
        if (i_req.cmd == fbfa_pkg::CMD_ADD) begin
            take = !r_valid && !i_pick.found;
        end else begin
            take = fits && (!i_pick.found || better);
        end
        rem_size = r_size - i_req.size;
    end

    // Candidate register towards the right neighbour
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pick <= '{found: 1'b1, size: r_size, addr: r_addr};
            r_slot <= MY_SLOT;
        end else begin
            r_pick <= i_pick;
            r_slot <= i_slot;
        end
    end

    // Entry payload
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_slot == MY_SLOT)) begin
            if (i_req.cmd == fbfa_pkg::CMD_ADD) begin
                r_size <= i_req.size;
                r_addr <= i_req.addr;
            end else begin
                r_size <= rem_size;
                r_addr <= r_addr + i_req.size;
            end
        end
    end

    // Entry valid: set by add, cleared when the remnant is too small
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr_en && (i_wr_slot == MY_SLOT)) begin
            if (i_req.cmd == fbfa_pkg::CMD_ADD) begin
                r_valid <= 1'b1;
            end else begin
                r_valid <= rem_size > i_req.min_rem;
            end
        end
    end

    assign o_pick = r_pick;
    assign o_slot = r_slot;

endmodule

`default_nettype wire

// File: rtl/free_block_fit_allocator.sv
// Free block fit allocator: a chain of table cells and the controller that
// runs the scan, write-back and result register.
// Depends on fbfa_pkg, fbfa_if and fbfa_cell.
//
// Usage:
//   i_in   : command words {cmd, block_size, block_addr}. Add (cmd 0) puts a
//            free block in the lowest empty slot; allocate (cmd 1) grants a
//            fitting block chosen by fit_policy and shrinks it.
//   o_out  : one result word {status, alloc_addr} per command.
//   i_cfg  : register writes, ready whenever out of reset; index 0 fit_policy,
//            index 1 min_remnant. Write only while no command is in flight.
// Timing: one command at a time. The candidate walks the chain of
//   TABLE_DEPTH cells one cell per cycle, then the write state writes back
//   and loads the result register, unless the output register is still
//   full; the controller then returns to idle, ready for the next command.
// Reset: all slots empty, fit_policy first fit, min_remnant 5.
// Stall: a result waits in the output register; the next command is taken
//   and scanned meanwhile, and its write-back waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module free_block_fit_allocator #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fbfa_in_if.sink     i_in,
    fbfa_out_if.source  o_out,
    fbfa_cfg_if.sink    i_cfg
);

    localparam int unsigned SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] LAST_STEP = SLOT_W'(TABLE_DEPTH - 1);

    fbfa_pkg::t_state              r_state, n_state;
    logic [SLOT_W-1:0]             r_step, n_step;
    fbfa_pkg::t_req                r_req;
    logic [fbfa_pkg::POL_W-1:0]    r_policy;
    logic [fbfa_pkg::SIZE_W-1:0]   r_min_rem;
    logic                          r_out_valid, n_out_valid;
    logic [fbfa_pkg::STATUS_W-1:0] r_status;
    logic [fbfa_pkg::ADDR_W-1:0]   r_alloc_addr;

    logic                          in_acc;
    logic                          wr_go;
    logic                          wr_en;
    logic [fbfa_pkg::STATUS_W-1:0] res_status;
    logic [fbfa_pkg::ADDR_W-1:0]   res_addr;

    fbfa_pkg::t_pick               w_pick [0:TABLE_DEPTH];
    logic [SLOT_W-1:0]             w_slot [0:TABLE_DEPTH];

    // Register writes
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= fbfa_pkg::POL_FIRST;
            r_min_rem <= fbfa_pkg::MIN_REMNANT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                fbfa_pkg::REG_FIT_POLICY:  r_policy  <= i_cfg.data[fbfa_pkg::POL_W-1:0];
                fbfa_pkg::REG_MIN_REMNANT: r_min_rem <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Command word capture
    assign in_acc = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= '{cmd: i_in.cmd, size: i_in.block_size, addr: i_in.block_addr,
                       policy: r_policy, min_rem: r_min_rem};
        end
    end

    // Chain of table cells
    assign w_pick[0] = '{found: 1'b0, size: '0, addr: '0};
    assign w_slot[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        fbfa_cell #(
            .SLOT_W (SLOT_W),
            .SLOT   (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_req     (r_req),
            .i_pick    (w_pick[g]),
            .i_slot    (w_slot[g]),
            .i_wr_en   (wr_en),
            .i_wr_slot (w_slot[TABLE_DEPTH]),
            .o_pick    (w_pick[g+1]),
            .o_slot    (w_slot[g+1])
        );
    end

    // Result of the finished scan
    always_comb begin
        res_addr = '0;
        if (r_req.cmd == fbfa_pkg::CMD_ADD) begin
            res_status = w_pick[TABLE_DEPTH].found ? fbfa_pkg::STATUS_DONE
                                                   : fbfa_pkg::STATUS_FULL;
        end else if (w_pick[TABLE_DEPTH].found) begin
            res_status = fbfa_pkg::STATUS_DONE;
            res_addr   = w_pick[TABLE_DEPTH].addr;
        end else begin
            res_status = fbfa_pkg::STATUS_NOFIT;
        end
    end

    // Controller state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fbfa_pkg::ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and handshakes
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !o_out.ready;
        i_in.ready  = 1'b0;
        wr_go       = 1'b0;
        unique case (r_state)
            fbfa_pkg::ST_IDLE: begin
                i_in.ready = i_rst_n;
                if (i_in.valid) begin
                    n_state = fbfa_pkg::ST_SCAN;
                    n_step  = '0;
                end
            end
            fbfa_pkg::ST_SCAN: begin
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = fbfa_pkg::ST_WRITE;
                end
            end
            fbfa_pkg::ST_WRITE: begin
                if (!r_out_valid || o_out.ready) begin
                    wr_go       = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = fbfa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fbfa_pkg::ST_IDLE;
            end
        endcase
    end

    assign wr_en = wr_go && w_pick[TABLE_DEPTH].found;

    // Result register
    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_status     <= res_status;
            r_alloc_addr <= res_addr;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_status;
    assign o_out.alloc_addr = r_alloc_addr;

endmodule

`default_nettype wire
